[sv/belt_block_cipher_defines.svh]
// ----------------------------------------------------------------------------
// belt_block_cipher_defines.svh
// Assertion macros shared by the cipher RTL.
// ----------------------------------------------------------------------------
`ifndef BELT_BLOCK_CIPHER_DEFINES_SVH
`define BELT_BLOCK_CIPHER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check that a condition implies a consequence on the same edge
`define BELT_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
// check that a condition implies a consequence at the next clock edge
`define BELT_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
`else
`define BELT_ASSERT_IMP(label, clk, rst, cond, cons, msg)
`define BELT_ASSERT_NEXT(label, clk, rst, cond, cons, msg)
`endif

`endif

[sv/belt_pkg.sv]
// ----------------------------------------------------------------------------
// belt_pkg
// Types, constants and the S-box / G function of the belt block cipher.
// ----------------------------------------------------------------------------
`default_nettype none
package belt_pkg;

  localparam int WORD_W  = 32;
  localparam int HALF_W  = 64;
  localparam int KEY_REGS = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  dec;
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } blk_t;

  // input transaction: operation and the two block halves
  typedef struct packed {
    logic              kind;
    logic [HALF_W-1:0] block_low;
    logic [HALF_W-1:0] block_high;
  } in_item_t;

  // output transaction: the two result halves
  typedef struct packed {
    logic [HALF_W-1:0] result_low;
    logic [HALF_W-1:0] result_high;
  } out_item_t;

  localparam logic [7:0] SBOX_H [256] = '{
    8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
    8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
    8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
    8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
    8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
    8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
    8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
    8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
    8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
    8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
    8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
    8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
    8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
    8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
    8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
    8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
  };

  // S-box on every byte, then rotate left by r
  function automatic word_t g_fn(input word_t u, input int r);
    word_t s;
    s = {SBOX_H[u[31:24]], SBOX_H[u[23:16]], SBOX_H[u[15:8]], SBOX_H[u[7:0]]};
    return (s << r) | (s >> (WORD_W - r));
  endfunction

endpackage
`default_nettype wire

[sv/belt_stream_if.sv]
// ----------------------------------------------------------------------------
// belt_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface belt_stream_if #(
  parameter type PAYLOAD_T = logic
);
  logic     valid;
  logic     ready;
  PAYLOAD_T payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/belt_block_cipher.sv]
// ----------------------------------------------------------------------------
// belt_block_cipher
// Pipelined belt (STB 34.101.31) encrypt/decrypt, one block per cycle if no stall.
// ----------------------------------------------------------------------------
// The block takes one 128-bit block per clock while the output is not stalled
// and returns it encrypted or decrypted under the 256-bit key in key registers
// 0..3. Each of the eight rounds is split into four register stages (one to
// two G functions each), so a block passes 32 pipeline registers and then the
// output register; throughput is one block per cycle while not stalled. The
// whole pipeline advances only when the output slot is free or being taken, so
// a stalled sink holds all blocks in place. Write the key only while no block
// is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "belt_block_cipher_defines.svh"
module belt_block_cipher #(
  parameter int ROUND_COUNT = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [belt_pkg::CFG_IDX_W:0] cfg_index,
  input  wire logic [belt_pkg::HALF_W-1:0] cfg_data,
  belt_stream_if.sink   in_ch,
  belt_stream_if.source out_ch
);
  import belt_pkg::*;

  localparam int STAGES = 4 * ROUND_COUNT;

  // key registers
  logic [HALF_W-1:0] key_reg [KEY_REGS];
  word_t th [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEY_REGS; k++) key_reg[k] <= '0;
    end else if (cfg_we && cfg_index < 3'(KEY_REGS)) begin
      key_reg[cfg_index[CFG_IDX_W-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int k = 0; k < KEY_REGS; k++) begin
      th[2*k]   = key_reg[k][WORD_W-1:0];
      th[2*k+1] = key_reg[k][HALF_W-1:WORD_W];
    end
  end

  // key word for offset m (1..7) of round i
  function automatic word_t rkey(input logic dec, input int i, input int m);
    int j;
    j = dec ? (7 * i - 7 + m) : (7 * i - 7 + m);
    return th[3'((j - 1) & 7)];
  endfunction

  // pipeline registers
  blk_t pipe [STAGES+1];
  logic vld  [STAGES+1];
  logic out_vld;
  logic [2*HALF_W-1:0] out_data;
  logic advance;

  assign advance = !out_vld || out_ch.ready;
  assign in_ch.ready = advance;

  always_comb begin
    pipe[0].dec = in_ch.payload.kind;
    pipe[0].a   = in_ch.payload.block_low[WORD_W-1:0];
    pipe[0].b   = in_ch.payload.block_low[HALF_W-1:WORD_W];
    pipe[0].c   = in_ch.payload.block_high[WORD_W-1:0];
    pipe[0].d   = in_ch.payload.block_high[HALF_W-1:WORD_W];
    vld[0]      = in_ch.valid;
  end

  // four stages per round
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int PH  = s % 4;
    localparam int RND = s / 4 + 1;
    blk_t x, y;
    word_t e;
    int ri;
    always_comb begin
      x  = pipe[s];
      y  = x;
      e  = '0;
      ri = x.dec ? (ROUND_COUNT + 1 - RND) : RND;
      case (PH)
        0: begin
          // first mixing pair
          y.b = x.b ^ g_fn(x.a + rkey(x.dec, ri, x.dec ? 7 : 1), 5);
          y.c = x.c ^ g_fn(x.d + rkey(x.dec, ri, x.dec ? 6 : 2), 21);
        end
        1: begin
          y.a = x.a - g_fn(x.b + rkey(x.dec, ri, x.dec ? 5 : 3), 13);
        end
        2: begin
          e   = g_fn(x.b + x.c + rkey(x.dec, ri, 4), 21) ^ word_t'(ri);
          y.b = x.b + e;
          y.c = x.c - e;
          y.d = x.d + g_fn(x.c - e + rkey(x.dec, ri, x.dec ? 3 : 5), 13);
        end
        default: begin
          y.b = x.b ^ g_fn(x.a + rkey(x.dec, ri, x.dec ? 2 : 6), 21);
          y.c = x.c ^ g_fn(x.d + rkey(x.dec, ri, x.dec ? 1 : 7), 5);
          // word permutation
          if (x.dec) begin
            y.a = y.c; y.c = x.d; y.d = y.b; y.b = x.a;
          end else begin
            y.a = y.b; y.b = x.d; y.d = y.c; y.c = x.a;
          end
        end
      endcase
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (advance) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) pipe[s+1] <= y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= vld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pipe[STAGES].dec)
        out_data <= {pipe[STAGES].b, pipe[STAGES].d, pipe[STAGES].a, pipe[STAGES].c};
      else
        out_data <= {pipe[STAGES].c, pipe[STAGES].a, pipe[STAGES].d, pipe[STAGES].b};
    end
  end

  assign out_ch.valid = out_vld;
  assign out_ch.payload.result_low  = out_data[HALF_W-1:0];
  assign out_ch.payload.result_high = out_data[2*HALF_W-1:HALF_W];

  `BELT_ASSERT_IMP(a_ready_stall, clk, rst, out_vld && !out_ch.ready, !in_ch.ready, "ready during stall")
  `BELT_ASSERT_NEXT(a_hold, clk, rst, out_vld && !out_ch.ready, out_vld && $stable(out_data), "output lost")
  `BELT_ASSERT_NEXT(a_flow, clk, rst, advance && vld[STAGES], out_vld, "result dropped")

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Block-level bench for the belt block cipher. Streams encrypt and decrypt
// blocks through the valid/ready input channel under several keys, predicts
// each output block with a behavioral cipher model and checks every output
// transaction in order. Sender gaps and sink stalls vary per phase.
// ----------------------------------------------------------------------------
module tb_top;
  import belt_pkg::*;

  localparam logic [CFG_IDX_W:0] REG_KEY0 = 0;
  localparam logic [CFG_IDX_W:0] REG_KEY1 = 1;
  localparam logic [CFG_IDX_W:0] REG_KEY2 = 2;
  localparam logic [CFG_IDX_W:0] REG_KEY3 = 3;
  localparam logic [CFG_IDX_W:0] REG_UNUSED_FIRST = 4;
  localparam int DRAIN_CYCLES = 40;

  // cipher model plus in-order store of expected output blocks
  class cipher_scoreboard;
    logic [63:0] key_reg [KEY_REGS];
    blk_t        pending_blocks [$];
    int          mismatches;

    function word_t round_key(int j);
      int n;
      n = (j - 1) & 7;
      return word_t'(key_reg[n >> 1] >> (32 * (n & 1)));
    endfunction

    function word_t sbox_rotate(word_t u, int r);
      word_t       s;
      logic [63:0] dbl;
      s   = {SBOX_H[u[31:24]], SBOX_H[u[23:16]], SBOX_H[u[15:8]], SBOX_H[u[7:0]]};
      dbl = {s, s} << r;
      return dbl[63:32];
    endfunction

    function blk_t cipher_block(blk_t x);
      word_t a, b, c, d, e, t;
      blk_t  y;
      int    i;
      a = x.a; b = x.b; c = x.c; d = x.d;
      y = '0;
      y.dec = x.dec;
      if (x.dec == KIND_ENCRYPT) begin
        for (i = 1; i <= 8; i++) begin
          b ^= sbox_rotate(a + round_key(7*i-6), 5);
          c ^= sbox_rotate(d + round_key(7*i-5), 21);
          a -= sbox_rotate(b + round_key(7*i-4), 13);
          e = sbox_rotate(b + c + round_key(7*i-3), 21) ^ word_t'(i);
          b += e;
          c -= e;
          d += sbox_rotate(c + round_key(7*i-2), 13);
          b ^= sbox_rotate(a + round_key(7*i-1), 21);
          c ^= sbox_rotate(d + round_key(7*i), 5);
          t = a; a = b; b = t;
          t = c; c = d; d = t;
          t = b; b = c; c = t;
        end
        y.a = b; y.b = d; y.c = a; y.d = c;
      end else begin
        for (i = 8; i >= 1; i--) begin
          b ^= sbox_rotate(a + round_key(7*i), 5);
          c ^= sbox_rotate(d + round_key(7*i-1), 21);
          a -= sbox_rotate(b + round_key(7*i-2), 13);
          e = sbox_rotate(b + c + round_key(7*i-3), 21) ^ word_t'(i);
          b += e;
          c -= e;
          d += sbox_rotate(c + round_key(7*i-4), 13);
          b ^= sbox_rotate(a + round_key(7*i-5), 21);
          c ^= sbox_rotate(d + round_key(7*i-6), 5);
          t = a; a = b; b = t;
          t = c; c = d; d = t;
          t = a; a = d; d = t;
        end
        y.a = c; y.b = a; y.c = d; y.d = b;
      end
      return y;
    endfunction

    function void note_input(blk_t x);
      pending_blocks.push_back(cipher_block(x));
    endfunction

    function void check_result(out_item_t y);
      blk_t exp_blk;
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output block %h_%h", y.result_high, y.result_low);
        return;
      end
      exp_blk = pending_blocks.pop_front();
      if (y.result_low !== {exp_blk.b, exp_blk.a}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result_low: expected %h actual %h", {exp_blk.b, exp_blk.a},
                   y.result_low);
      end
      if (y.result_high !== {exp_blk.d, exp_blk.c}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result_high: expected %h actual %h", {exp_blk.d, exp_blk.c},
                   y.result_high);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W:0]   cfg_index = '0;
  logic [HALF_W-1:0]    cfg_data = '0;
  int                   gap_pct = 0;
  int                   stall_pct = 0;
  cipher_scoreboard     sb = new();

  belt_stream_if #(.PAYLOAD_T(in_item_t))  in_if ();
  belt_stream_if #(.PAYLOAD_T(out_item_t)) out_if ();

  belt_block_cipher uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  always #4 clk = ~clk;

  initial begin
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
  end

  // randomly stall the sink
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // check each output transaction
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) sb.check_result(out_if.payload);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // write one key register; the model ignores indexes above the key range
  task automatic write_key(logic [CFG_IDX_W:0] idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx < KEY_REGS) sb.key_reg[idx[CFG_IDX_W-1:0]] = value;
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] k3);
    write_key(REG_KEY0, k0);
    write_key(REG_KEY1, k1);
    write_key(REG_KEY2, k2);
    write_key(REG_KEY3, k3);
  endtask

  // hold until every block has come out and the pipeline is empty
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // present one block, with an optional leading gap, and wait for acceptance
  task automatic send_block(logic kind, logic [63:0] lo, logic [63:0] hi);
    blk_t     x;
    in_item_t item;
    int       gap;
    gap = 0;
    while ($urandom_range(99) < gap_pct && gap < 30) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    x.dec = kind;
    {x.b, x.a} = lo;
    {x.d, x.c} = hi;
    item.kind       = kind;
    item.block_low  = lo;
    item.block_high = hi;
    in_if.valid   <= 1'b1;
    in_if.payload <= item;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(x);
  endtask

  // encrypt, then decrypt the predicted ciphertext to check the round trip
  task automatic round_trip(logic [63:0] lo, logic [63:0] hi);
    blk_t p, q;
    p.dec = KIND_ENCRYPT;
    {p.b, p.a} = lo;
    {p.d, p.c} = hi;
    q = sb.cipher_block(p);
    send_block(KIND_ENCRYPT, lo, hi);
    send_block(KIND_DECRYPT, {q.b, q.a}, {q.d, q.c});
  endtask

  task automatic random_blocks(int count);
    int n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0) round_trip(rand64(), rand64());
      else send_block($urandom_range(1), rand64(), rand64());
    end
  endtask

  initial begin
    sb.mismatches = 0;
    for (int k = 0; k < KEY_REGS; k++) sb.key_reg[k] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset key, field extremes, both kinds
    send_block(KIND_ENCRYPT, '0, '0);
    send_block(KIND_DECRYPT, '0, '0);
    send_block(KIND_ENCRYPT, '1, '1);
    send_block(KIND_DECRYPT, '1, '1);
    round_trip(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    drain();

    // directed: all-ones key, ignored register writes, round trips
    load_key('1, '1, '1, '1);
    write_key(REG_UNUSED_FIRST, rand64());
    write_key(REG_UNUSED_FIRST + 3'd3, '1);
    send_block(KIND_ENCRYPT, '0, '1);
    send_block(KIND_DECRYPT, '1, '0);
    round_trip(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
    round_trip('1, '0);
    drain();

    // random phases: none, sender gaps, sink stalls, both
    load_key(rand64(), rand64(), rand64(), rand64());
    gap_pct = 0; stall_pct = 0;
    random_blocks(100);
    drain();
    load_key(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, rand64(), '0);
    gap_pct = 86; stall_pct = 0;
    random_blocks(80);
    drain();
    load_key(rand64(), rand64(), rand64(), rand64());
    write_key(REG_UNUSED_FIRST + 3'd1, rand64());
    gap_pct = 0; stall_pct = 86;
    random_blocks(80);
    drain();
    load_key('0, rand64(), '1, rand64());
    gap_pct = 10; stall_pct = 10;
    random_blocks(80);
    drain();

    if (sb.mismatches == 0 && sb.pending_blocks.size() == 0)
      $display("belt_block_cipher verification clean");
    else
      $display("belt_block_cipher verification failed");
    $finish;
  end

  initial begin
    #4ms;
    $display("belt_block_cipher verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/belt_pkg.sv
sv/belt_stream_if.sv
sv/belt_block_cipher.sv
verif/tb_top.sv
